### design/bsec_pkg.sv
// ----------------------------------------------------------------------------
// bsec_pkg
// Shared widths, register indexes and event reason codes for the battery
// SOC event classifier.
// ----------------------------------------------------------------------------
package bsec_pkg;

  // payload widths
  localparam int unsigned SOC_W     = 16;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned REASON_W  = 3;
  localparam int unsigned GAP_RND_W = 9;

  // width of the hold-off timebase, elapsed time wraps modulo 2^TIME_BITS
  localparam int unsigned TIME_BITS = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECTED_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CODE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_SECS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_THRESHOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVERGE_THRESHOLD = 3'd5;

  // register reset values
  localparam logic [STATUS_W-1:0]   CONNECTED_CODE_RST    = 8'd0;
  localparam logic [STATUS_W-1:0]   DISCONNECTED_CODE_RST = 8'd1;
  localparam logic [STATUS_W-1:0]   FULL_CODE_RST         = 8'd2;
  localparam logic [CFG_DATA_W-1:0] HOLDOFF_SECS_RST      = 16'd1800;
  localparam logic [CFG_DATA_W-1:0] SKIP_THRESHOLD_RST    = 16'd512;
  localparam logic [CFG_DATA_W-1:0] DIVERGE_THRESHOLD_RST = 16'd1024;

  // half of one percent in Q8.8, added before truncation for half-up rounding
  localparam logic [SOC_W:0] ROUND_HALF = 17'd128;

  // event reasons
  typedef enum logic [REASON_W-1:0] {
    REASON_NONE         = 3'd0,
    REASON_CONNECTED    = 3'd1,
    REASON_DISCONNECTED = 3'd2,
    REASON_FULL         = 3'd3,
    REASON_SKIP         = 3'd4,
    REASON_DIVERGE      = 3'd5
  } reason_t;

  // absolute difference of two SOC values
  function automatic logic [SOC_W-1:0] soc_abs_diff(input logic [SOC_W-1:0] a,
                                                    input logic [SOC_W-1:0] b);
    soc_abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### design/bsec_ifs.sv
// ----------------------------------------------------------------------------
// bsec channel interfaces
// Valid/ready channels carrying one sample request and one event result.
// ----------------------------------------------------------------------------

// sample request channel
interface bsec_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsec_pkg::SOC_W-1:0]    gauge_soc;
  logic [bsec_pkg::SOC_W-1:0]    system_soc;
  logic [bsec_pkg::STATUS_W-1:0] status_code;
  logic [bsec_pkg::NOW_W-1:0]    now_secs;

  modport source (output valid, gauge_soc, system_soc, status_code, now_secs,
                  input ready);
  modport sink   (input valid, gauge_soc, system_soc, status_code, now_secs,
                  output ready);
endinterface

// event result channel
interface bsec_out_if;
  logic                          valid;
  logic                          ready;
  logic                          report_valid;
  logic [bsec_pkg::REASON_W-1:0] event_reason;

  modport source (output valid, report_valid, event_reason, input ready);
  modport sink   (input valid, report_valid, event_reason, output ready);
endinterface

### design/battery_soc_event_classifier.sv
// ----------------------------------------------------------------------------
// battery_soc_event_classifier
// Classifies fuel-gauge samples into charger status events, percent skips
// and gauge/system divergences, with a hold-off after abnormal events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  in_ch   | sink      | valid / ready    | gauge_soc, system_soc,
//          |           |                  | status_code, now_secs
//  out_ch  | source    | valid / ready    | report_valid, event_reason
//  cfg_*   | sink      | cfg_we (no wait) | cfg_idx, cfg_wdata
//
//  one request per cycle sustained while the result side is not stalled; a
//  request loads the input register, then the result register that offers it
//  the decision logic is a single pass over the input register and the
//  classifier state, which updates at the edge that loads the result register
//  rst_n is synchronous: valid flags and configuration return to defaults,
//  state is cleared, payload registers are not reset
//  a stalled result holds in place; the input register still takes a request
//  while the result register is free or being drained in the same cycle
// ----------------------------------------------------------------------------
module battery_soc_event_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  bsec_in_if.sink                           in_ch,
  bsec_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bsec_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bsec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [bsec_pkg::STATUS_W-1:0]   connected_code_r;
  logic [bsec_pkg::STATUS_W-1:0]   disconnected_code_r;
  logic [bsec_pkg::STATUS_W-1:0]   full_code_r;
  logic [bsec_pkg::CFG_DATA_W-1:0] holdoff_secs_r;
  logic [bsec_pkg::CFG_DATA_W-1:0] skip_threshold_r;
  logic [bsec_pkg::CFG_DATA_W-1:0] diverge_threshold_r;

  // input register
  logic                          s1_valid_r;
  logic [bsec_pkg::SOC_W-1:0]    s1_gauge_r;
  logic [bsec_pkg::SOC_W-1:0]    s1_sys_r;
  logic [bsec_pkg::STATUS_W-1:0] s1_status_r;
  logic [bsec_pkg::NOW_W-1:0]    s1_now_r;

  // classifier state
  logic [bsec_pkg::STATUS_W-1:0]  last_status_r,      last_status_nxt;
  logic [bsec_pkg::SOC_W-1:0]     last_sys_r;
  logic [bsec_pkg::GAP_RND_W-1:0] last_gap_rnd_r,     last_gap_rnd_nxt;
  logic                           holdoff_active_r,   holdoff_active_nxt;
  logic [bsec_pkg::TIME_BITS-1:0] holdoff_start_r,    holdoff_start_nxt;

  // result register
  logic                           out_valid_r;
  bsec_pkg::reason_t              out_reason_r,       out_reason_nxt;

  // handshake
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // configuration writes, out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_code_r    <= bsec_pkg::CONNECTED_CODE_RST;
      disconnected_code_r <= bsec_pkg::DISCONNECTED_CODE_RST;
      full_code_r         <= bsec_pkg::FULL_CODE_RST;
      holdoff_secs_r      <= bsec_pkg::HOLDOFF_SECS_RST;
      skip_threshold_r    <= bsec_pkg::SKIP_THRESHOLD_RST;
      diverge_threshold_r <= bsec_pkg::DIVERGE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        bsec_pkg::CFG_CONNECTED_CODE:    connected_code_r    <= cfg_wdata[bsec_pkg::STATUS_W-1:0];
        bsec_pkg::CFG_DISCONNECTED_CODE: disconnected_code_r <= cfg_wdata[bsec_pkg::STATUS_W-1:0];
        bsec_pkg::CFG_FULL_CODE:         full_code_r         <= cfg_wdata[bsec_pkg::STATUS_W-1:0];
        bsec_pkg::CFG_HOLDOFF_SECS:      holdoff_secs_r      <= cfg_wdata;
        bsec_pkg::CFG_SKIP_THRESHOLD:    skip_threshold_r    <= cfg_wdata;
        bsec_pkg::CFG_DIVERGE_THRESHOLD: diverge_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gauge_r  <= in_ch.gauge_soc;
      s1_sys_r    <= in_ch.system_soc;
      s1_status_r <= in_ch.status_code;
      s1_now_r    <= in_ch.now_secs;
    end
  end

  // decision logic
  logic [bsec_pkg::TIME_BITS-1:0] now_t;
  logic [bsec_pkg::TIME_BITS-1:0] elapsed;
  logic                           holdoff_live;
  logic [bsec_pkg::SOC_W-1:0]     gap;
  logic [bsec_pkg::SOC_W:0]       gap_sum;
  logic [bsec_pkg::GAP_RND_W-1:0] gap_rnd;
  logic [bsec_pkg::SOC_W-1:0]     sys_jump;
  logic                           is_skip;
  logic                           is_diverge;

  // timestamp sized to the hold-off timebase, zero-extended or truncated
  assign now_t        = bsec_pkg::TIME_BITS'(s1_now_r);
  assign elapsed      = now_t - holdoff_start_r;
  assign holdoff_live = holdoff_active_r &&
                        (elapsed <= bsec_pkg::TIME_BITS'(holdoff_secs_r));
  assign gap          = bsec_pkg::soc_abs_diff(s1_sys_r, s1_gauge_r);
  // half-up rounding to whole percent
  assign gap_sum      = {1'b0, gap} + bsec_pkg::ROUND_HALF;
  assign gap_rnd      = gap_sum[bsec_pkg::SOC_W:bsec_pkg::SOC_W-bsec_pkg::GAP_RND_W+1];
  assign sys_jump     = bsec_pkg::soc_abs_diff(s1_sys_r, last_sys_r);
  assign is_skip      = sys_jump >= skip_threshold_r;
  assign is_diverge   = (gap_rnd != last_gap_rnd_r) && (gap >= diverge_threshold_r);

  always_comb begin
    out_reason_nxt     = bsec_pkg::REASON_NONE;
    last_status_nxt    = last_status_r;
    last_gap_rnd_nxt   = last_gap_rnd_r;
    holdoff_active_nxt = holdoff_live;
    holdoff_start_nxt  = holdoff_start_r;
    if (s1_status_r != last_status_r) begin
      // status change, connected checked first when codes coincide
      last_status_nxt = s1_status_r;
      if (s1_status_r == connected_code_r) begin
        out_reason_nxt = bsec_pkg::REASON_CONNECTED;
      end else if (s1_status_r == disconnected_code_r) begin
        out_reason_nxt = bsec_pkg::REASON_DISCONNECTED;
      end else if (s1_status_r == full_code_r) begin
        out_reason_nxt = bsec_pkg::REASON_FULL;
      end
    end else if (!holdoff_live) begin
      // abnormal events, a skip wins over a divergence
      if (is_skip) begin
        out_reason_nxt     = bsec_pkg::REASON_SKIP;
        holdoff_active_nxt = 1'b1;
        holdoff_start_nxt  = now_t;
      end else if (is_diverge) begin
        out_reason_nxt     = bsec_pkg::REASON_DIVERGE;
        holdoff_active_nxt = 1'b1;
        holdoff_start_nxt  = now_t;
        last_gap_rnd_nxt   = gap_rnd;
      end
    end
  end

  // classifier state, updated as the request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r    <= '0;
      last_sys_r       <= '0;
      last_gap_rnd_r   <= '0;
      holdoff_active_r <= 1'b0;
      holdoff_start_r  <= '0;
    end else if (s1_adv) begin
      last_status_r    <= last_status_nxt;
      last_sys_r       <= s1_sys_r;
      last_gap_rnd_r   <= last_gap_rnd_nxt;
      holdoff_active_r <= holdoff_active_nxt;
      holdoff_start_r  <= holdoff_start_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_reason_r <= out_reason_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_reason = out_reason_r;
  assign out_ch.report_valid = (out_reason_r != bsec_pkg::REASON_NONE);

endmodule

### design/bsec_checker.sv
// ----------------------------------------------------------------------------
// bsec_checker
// Port-level checks on the battery SOC event classifier, bound to the top.
// ----------------------------------------------------------------------------
module bsec_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_report_valid,
  input logic [bsec_pkg::REASON_W-1:0] out_event_reason
);

  // a stalled result stays offered with the same reason
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_reason))
    else $error("result dropped or changed while stalled");

  // the report flag follows the reason code
  a_report_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_report_valid == (out_event_reason != bsec_pkg::REASON_NONE)))
    else $error("report_valid disagrees with event_reason");

  // a fresh result comes from a request accepted into the input register before it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // a draining result side never blocks new requests
  a_no_bubble: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("request side stalled while result side drains");

endmodule

bind battery_soc_event_classifier bsec_checker u_bsec_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_report_valid (out_ch.report_valid),
  .out_event_reason (out_ch.event_reason)
);
